// ===== sv/u8u16_pkg.sv =====
// Shared types, constants and helpers for the UTF-8 to UTF-16 transcoder.
package u8u16_pkg;

	localparam int ByteW    = 8;
	localparam int UnitW    = 16;
	localparam int CpW      = 21;
	localparam int MaxUnits = 4;
	localparam int CntW     = $clog2(MaxUnits + 1);
	localparam int PendDepth = 3;

	localparam logic [UnitW-1:0] UnitQmark = 16'h003F;
	localparam logic [UnitW-1:0] UnitTerm  = 16'h0000;
	localparam logic [UnitW-1:0] SurHi     = 16'hD800;
	localparam logic [UnitW-1:0] SurLo     = 16'hDC00;
	localparam logic [CpW-1:0]   SuppBase  = 21'h10000;

	// sequence lengths announced by a lead byte
	localparam logic [2:0] LenBad = 3'd0;
	localparam logic [2:0] LenOne = 3'd1;
	localparam logic [2:0] LenTwo = 3'd2;
	localparam logic [2:0] LenThr = 3'd3;
	localparam logic [2:0] LenFou = 3'd4;

	// words produced by one input byte, oldest in entry 0
	typedef struct packed {
		logic [MaxUnits-1:0][UnitW-1:0] units;
		logic [CntW-1:0]                cnt;
	} u8u16_res_t;

	function automatic logic [2:0] lead_len(input logic [ByteW-1:0] b);
		logic [2:0] len;
		if (b[7] == 1'b0) begin
			len = LenOne;
		end else if (b[7:5] == 3'b110) begin
			len = LenTwo;
		end else if (b[7:4] == 4'b1110) begin
			len = LenThr;
		end else if (b[7:3] == 5'b11110) begin
			len = LenFou;
		end else begin
			len = LenBad;
		end
		return len;
	endfunction

endpackage

// ===== sv/u8u16_decode.sv =====
// Pending-byte buffer and single-pass decode of one UTF-8 byte into up to four words.
module u8u16_decode (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      accept,
	input  logic [u8u16_pkg::ByteW-1:0] in_byte,
	input  logic                      at_end,
	output u8u16_pkg::u8u16_res_t     res
);

	logic [u8u16_pkg::ByteW-1:0] pend_q [u8u16_pkg::PendDepth];
	logic [1:0]                  pend_cnt_q;

	logic                        cont, has_pend, complete, append, broken, fresh;
	logic [2:0]                  need, blen;
	logic [1:0]                  qn;
	logic [1:0]                  tn;
	logic [u8u16_pkg::CpW-1:0]   cp, cpv;
	logic [u8u16_pkg::UnitW-1:0] tail0, tail1;
	logic [1:0]                  tidx;

	always_comb begin
		has_pend = (pend_cnt_q != 2'd0);
		cont     = (in_byte[7:6] == 2'b10);
		need     = u8u16_pkg::lead_len(pend_q[0]);
		blen     = u8u16_pkg::lead_len(in_byte);
		complete = !at_end && has_pend && cont && (({1'b0, pend_cnt_q} + 3'd1) >= need);
		append   = !at_end && has_pend && cont && !complete;
		broken   = !at_end && has_pend && !cont;
		fresh    = !at_end && (!has_pend || !cont);
		qn       = (at_end || broken) ? pend_cnt_q : 2'd0;

		case (need)
			u8u16_pkg::LenTwo: cp = {10'd0, pend_q[0][4:0], in_byte[5:0]};
			u8u16_pkg::LenThr: cp = {5'd0, pend_q[0][3:0], pend_q[1][5:0], in_byte[5:0]};
			default: cp = {pend_q[0][2:0], pend_q[1][5:0], pend_q[2][5:0], in_byte[5:0]};
		endcase
		cpv = cp - u8u16_pkg::SuppBase;

		tail0 = u8u16_pkg::UnitTerm;
		tail1 = u8u16_pkg::UnitTerm;
		tn    = 2'd0;
		if (at_end) begin
			tn = 2'd1;
		end else if (complete) begin
			if (cp >= u8u16_pkg::SuppBase) begin
				tail0 = u8u16_pkg::SurHi | {5'd0, cpv[20:10]};
				tail1 = u8u16_pkg::SurLo | {6'd0, cpv[9:0]};
				tn    = 2'd2;
			end else begin
				tail0 = cp[15:0];
				tn    = 2'd1;
			end
		end else if (fresh) begin
			if (blen == u8u16_pkg::LenOne) begin
				tail0 = {8'd0, in_byte};
				tn    = 2'd1;
			end else if (blen == u8u16_pkg::LenBad) begin
				tail0 = u8u16_pkg::UnitQmark;
				tn    = 2'd1;
			end
		end

		// qmarks for the dropped bytes first, then the tail words
		for (int i = 0; i < u8u16_pkg::MaxUnits; i++) begin
			tidx = 2'(i) - qn;
			if (2'(i) < qn) begin
				res.units[i] = u8u16_pkg::UnitQmark;
			end else if (tidx == 2'd0) begin
				res.units[i] = tail0;
			end else begin
				res.units[i] = tail1;
			end
		end
		res.cnt = {1'b0, qn} + {1'b0, tn};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q <= 2'd0;
		end else if (accept) begin
			if (append) begin
				pend_cnt_q <= pend_cnt_q + 2'd1;
			end else if (fresh && blen >= u8u16_pkg::LenTwo) begin
				pend_cnt_q <= 2'd1;
			end else begin
				pend_cnt_q <= 2'd0;
			end
		end
	end

	// buffer bytes carry no reset; only entries below the count are read
	always_ff @(posedge clk) begin
		if (accept) begin
			if (fresh && blen >= u8u16_pkg::LenTwo) begin
				pend_q[0] <= in_byte;
			end
			if (append && pend_cnt_q == 2'd1) begin
				pend_q[1] <= in_byte;
			end
			if (append && pend_cnt_q == 2'd2) begin
				pend_q[2] <= in_byte;
			end
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && at_end |=> pend_cnt_q == 2'd0)
		else $error("pending bytes left after end of string");

	a_res_bound: assert property (@(posedge clk) disable iff (!arst_n)
		has_pend |-> res.cnt <= 3'(u8u16_pkg::MaxUnits))
		else $error("decode produced too many words");

	a_pend_lead: assert property (@(posedge clk) disable iff (!arst_n)
		has_pend |-> need >= u8u16_pkg::LenTwo)
		else $error("held bytes do not start with a lead");

endmodule

// ===== sv/utf8_to_utf16_transcoder.sv =====
// Top level: UTF-8 byte stream in, UTF-16 word stream out.
//
// channel   dir  tdata              tlast          meaning
// s_*       in   [7:0] in_byte      at_end         one UTF-8 byte, or end of string
// m_*       out  [15:0] out_unit    last_of_run    one UTF-16 word
//
// Each accepted byte is decoded in the cycle it is accepted and its 0..4 words
// land in the result register; they leave one per cycle while m_tready is high,
// through the single output port.
// A new byte is taken while the last word of the previous one is taken.
// arst_n clears the pending count and the word count; word data carry no reset.
// Stalls on m_tready hold the current word and back-pressure s_tready.
module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // at_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [15:0] out_unit
	output logic        m_tlast    // last_of_run
);

	u8u16_pkg::u8u16_res_t res;

	logic [u8u16_pkg::MaxUnits-1:0][u8u16_pkg::UnitW-1:0] units_q;
	logic [u8u16_pkg::CntW-1:0]                           left_q;
	logic                                                 take, accept;

	assign m_tvalid = (left_q != '0);
	assign m_tdata  = units_q[0];
	assign m_tlast  = (left_q == u8u16_pkg::CntW'(1));
	assign take     = m_tvalid && m_tready;
	// room once the result register is empty or its last word is leaving
	assign s_tready = !m_tvalid || (take && m_tlast);
	assign accept   = s_tvalid && s_tready;

	u8u16_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (s_tdata),
		.at_end  (s_tlast),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (accept) begin
			left_q <= res.cnt;
		end else if (take) begin
			left_q <= left_q - u8u16_pkg::CntW'(1);
		end
	end

	// word queue shifts down as words are taken
	always_ff @(posedge clk) begin
		if (accept) begin
			units_q <= res.units;
		end else if (take) begin
			for (int i = 0; i < u8u16_pkg::MaxUnits - 1; i++) begin
				units_q[i] <= units_q[i+1];
			end
		end
	end

	a_left_bound: assert property (@(posedge clk) disable iff (!arst_n)
		left_q <= u8u16_pkg::CntW'(u8u16_pkg::MaxUnits))
		else $error("result count out of range");

	a_ready_gate: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (left_q == '0) || (left_q == u8u16_pkg::CntW'(1) && m_tready))
		else $error("byte taken while words still pending");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		take && left_q > u8u16_pkg::CntW'(1) |=> left_q == $past(left_q) - u8u16_pkg::CntW'(1))
		else $error("word count did not step down");

	a_shift: assert property (@(posedge clk) disable iff (!arst_n)
		take && left_q > u8u16_pkg::CntW'(1) |=> m_tdata == $past(units_q[1]))
		else $error("next word not presented");

endmodule
